// File: rtl/sst_pkg.sv
`timescale 1ns / 1ps

package sst_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int KEY_CHARS   = 6;

   localparam int KEY_W   = KEY_CHARS * 8;
   localparam int LOC_W   = 16;
   localparam int ENTRY_W = KEY_W + LOC_W;
   localparam int ADDR_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);

   // stream widths: key and location in tdata, rounded up to whole bytes
   localparam int REQ_DATA_W = ((KEY_W + LOC_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((KEY_W + LOC_W + 7) / 8) * 8;
   localparam int MODE_W     = 2;
   localparam int STATUS_W   = 3;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_FIND   = 2'd1,
      MODE_CLEAR  = 2'd2,
      MODE_LIST   = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_INSERTED  = 3'd0,
      STAT_DUPLICATE = 3'd1,
      STAT_FOUND     = 3'd2,
      STAT_NOT_FOUND = 3'd3,
      STAT_FULL      = 3'd4,
      STAT_LISTED    = 3'd5,
      STAT_EMPTY     = 3'd6
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH,
      S_SEARCH_CMP,
      S_PROBE,
      S_DECIDE,
      S_SHIFT,
      S_SHIFT_WR,
      S_RESP,
      S_LIST_OUT
   } state_type;

   // one result offered by the sequencer to the output register
   typedef struct packed {
      logic              valid;
      status_type        status;
      logic [KEY_W-1:0]  key;
      logic [LOC_W-1:0]  loc;
      logic              last;
   } sst_res_type;

endpackage

// File: rtl/sst_ram.sv
`timescale 1ns / 1ps

module sst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      // hold read data while no read is issued
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/sst_ctrl.sv
`timescale 1ns / 1ps

module sst_ctrl import sst_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  mode_type           req_mode,
   input  logic [KEY_W-1:0]   req_key,
   input  logic [LOC_W-1:0]   req_loc,
   output logic               ram_we,
   output logic [ADDR_W-1:0]  ram_waddr,
   output logic [ENTRY_W-1:0] ram_wdata,
   output logic               ram_re,
   output logic [ADDR_W-1:0]  ram_raddr,
   input  logic [ENTRY_W-1:0] ram_rdata,
   output sst_res_type        res,
   input  logic               res_ready
);

   state_type          state_ff, state_in;
   mode_type           mode_ff, mode_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [LOC_W-1:0]   loc_ff, loc_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   lo_ff, lo_in;
   logic [CNT_W-1:0]   hi_ff, hi_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               match_ff, match_in;
   logic [LOC_W-1:0]   hit_loc_ff, hit_loc_in;
   status_type         res_status_ff, res_status_in;

   logic [CNT_W:0]     mid_sum;
   logic [CNT_W-1:0]   mid;
   logic [CNT_W-1:0]   idx_inc;
   logic [CNT_W-1:0]   idx_dec;
   logic [KEY_W-1:0]   rd_key;
   logic [LOC_W-1:0]   rd_loc;
   logic               list_last;

   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = mid_sum[CNT_W:1];
   assign idx_inc   = idx_ff + CNT_W'(1);
   assign idx_dec   = idx_ff - CNT_W'(1);
   assign rd_key    = ram_rdata[ENTRY_W-1:LOC_W];
   assign rd_loc    = ram_rdata[LOC_W-1:0];
   assign list_last = (idx_inc == count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      loc_ff        <= loc_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      idx_ff        <= idx_in;
      match_ff      <= match_in;
      hit_loc_ff    <= hit_loc_in;
      res_status_ff <= res_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      loc_in        = loc_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      idx_in        = idx_ff;
      match_in      = match_ff;
      hit_loc_in    = hit_loc_ff;
      res_status_in = res_status_ff;
      req_ready     = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      ram_re        = 1'b0;
      ram_raddr     = '0;
      res           = '0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mode_in = req_mode;
               key_in  = req_key;
               loc_in  = req_loc;
               lo_in   = '0;
               hi_in   = count_ff;
               idx_in  = '0;
               case (req_mode)
                  MODE_CLEAR: begin
                     count_in      = '0;
                     res_status_in = STAT_EMPTY;
                     state_in      = S_RESP;
                  end
                  MODE_LIST: begin
                     if (count_ff == '0) begin
                        res_status_in = STAT_EMPTY;
                        state_in      = S_RESP;
                     end else begin
                        ram_re   = 1'b1;
                        state_in = S_LIST_OUT;
                     end
                  end
                  default: begin
                     state_in = S_SEARCH;
                  end
               endcase
            end
         end

         S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               ram_re    = 1'b1;
               ram_raddr = mid[ADDR_W-1:0];
               state_in  = S_SEARCH_CMP;
            end else if (lo_ff < count_ff) begin
               ram_re    = 1'b1;
               ram_raddr = lo_ff[ADDR_W-1:0];
               state_in  = S_PROBE;
            end else begin
               match_in = 1'b0;
               state_in = S_DECIDE;
            end
         end

         S_SEARCH_CMP: begin
            if (rd_key < key_ff) begin
               lo_in = mid + CNT_W'(1);
            end else begin
               hi_in = mid;
            end
            state_in = S_SEARCH;
         end

         S_PROBE: begin
            match_in   = (rd_key == key_ff);
            hit_loc_in = rd_loc;
            state_in   = S_DECIDE;
         end

         S_DECIDE: begin
            if (mode_ff == MODE_FIND) begin
               res_status_in = match_ff ? STAT_FOUND : STAT_NOT_FOUND;
               state_in      = S_RESP;
            end else if (match_ff) begin
               res_status_in = STAT_DUPLICATE;
               state_in      = S_RESP;
            end else if (count_ff == CNT_W'(TABLE_DEPTH)) begin
               res_status_in = STAT_FULL;
               state_in      = S_RESP;
            end else begin
               idx_in   = count_ff;
               state_in = S_SHIFT;
            end
         end

         S_SHIFT: begin
            if (idx_ff > lo_ff) begin
               ram_re    = 1'b1;
               ram_raddr = idx_dec[ADDR_W-1:0];
               state_in  = S_SHIFT_WR;
            end else begin
               ram_we        = 1'b1;
               ram_waddr     = lo_ff[ADDR_W-1:0];
               ram_wdata     = {key_ff, loc_ff};
               count_in      = count_ff + CNT_W'(1);
               res_status_in = STAT_INSERTED;
               state_in      = S_RESP;
            end
         end

         S_SHIFT_WR: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff[ADDR_W-1:0];
            ram_wdata = ram_rdata;
            idx_in    = idx_dec;
            state_in  = S_SHIFT;
         end

         S_RESP: begin
            res.valid  = 1'b1;
            res.status = res_status_ff;
            res.loc    = (res_status_ff == STAT_FOUND) ? hit_loc_ff : '0;
            res.last   = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         S_LIST_OUT: begin
            res.valid  = 1'b1;
            res.status = STAT_LISTED;
            res.key    = rd_key;
            res.loc    = rd_loc;
            res.last   = list_last;
            if (res_ready) begin
               if (list_last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in    = idx_inc;
                  ram_re    = 1'b1;
                  ram_raddr = idx_inc[ADDR_W-1:0];
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/sst_outreg.sv
`timescale 1ns / 1ps

module sst_outreg import sst_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  sst_res_type           res,
   output logic                  res_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [STATUS_W-1:0]   rsp_tuser,
   output logic                  rsp_tlast
);

   logic                  valid_ff;
   logic [RSP_DATA_W-1:0] data_ff;
   logic [STATUS_W-1:0]   user_ff;
   logic                  last_ff;

   assign res_ready = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (res_ready) begin
         valid_ff <= res.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res.valid) begin
         data_ff <= RSP_DATA_W'({res.loc, res.key});
         user_ff <= res.status;
         last_ff <= res.last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule

// File: rtl/sorted_symbol_table.sv
`timescale 1ns / 1ps
// Sequence: clear goes straight to its response; find runs s search steps (s up to ceil(log2(n+1)),
//   n entries), then probes the lower bound unless past the last key; insert finds, then moves
//   entries up one at a time; list gives one entry a cycle while the response is not stalled.
// Throughput: one request at a time; the next is taken once the sequencer has handed its
//   response on, so a request costs its search steps and entry moves.
// Reset: synchronous, active high; empties the table and drops any pending response.

module sorted_symbol_table import sst_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [47:0] key, [63:48] location
   input  logic [MODE_W-1:0]     req_tuser,  // [1:0] mode
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [47:0] key_out, [63:48] location_out
   output logic [STATUS_W-1:0]   rsp_tuser,  // [2:0] status
   output logic                  rsp_tlast   // last
);

   // table memory: each word holds {key, location}, kept sorted by key
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic               ram_re;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;

   sst_res_type        res;
   logic               res_ready;

   sst_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Sequencer: binary search for the lower bound, probe that entry, then
   // move entries up one at a time (read, then write back one slot higher)
   // before writing the new entry. Reads and writes never hit the same
   // entry in the same cycle, so no forwarding is needed.
   sst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_mode  (mode_type'(req_tuser)),
      .req_key   (req_tdata[KEY_W-1:0]),
      .req_loc   (req_tdata[KEY_W+LOC_W-1:KEY_W]),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .res       (res),
      .res_ready (res_ready)
   );

   // Output register: hold a finished response while the sequencer
   // already takes the next request.
   sst_outreg u_out (
      .clock      (clock),
      .reset      (reset),
      .res        (res),
      .res_ready  (res_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: rtl/sst_checker.sv
`timescale 1ns / 1ps

module sst_checker import sst_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [MODE_W-1:0]     req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [STATUS_W-1:0]   rsp_tuser,
   input logic                  rsp_tlast
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // one request at a time: busy right after a request is taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // only list entries may leave a run open
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STAT_LISTED |-> rsp_tlast)
      else $error("non-list response without last");

   // key field is zero outside list entries
   a_key_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STAT_LISTED |-> rsp_tdata[KEY_W-1:0] == '0)
      else $error("key on non-list response");

   // reset drops any pending response
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind sorted_symbol_table sst_checker u_sst_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// File: verif/sorted_symbol_table_tb.sv
`timescale 1ns / 1ps

module sorted_symbol_table_tb;
   import sst_pkg::*;

   // Cycles with no handshake on either side before the run is abandoned. The slowest request is
   // an insert that moves 63 entries; even with the longest sender gap and response stall added
   // to it, the limit leaves ample margin.
   localparam int IDLE_LIMIT     = 3000;
   localparam int REQUEST_TARGET = 280;
   localparam int REPORT_CAP     = 40;

   // One response as seen on the response channel.
   typedef struct packed {
      status_type       status;
      logic [KEY_W-1:0] key;
      logic [LOC_W-1:0] loc;
      logic             last;
   } lookup_result_type;

   // Shadow of the symbol table. Predict the responses to each accepted request,
   // then match them in order against what the block returns.
   class table_tracker;
      logic [KEY_W-1:0]  sorted_keys[$];
      logic [LOC_W-1:0]  sorted_locs[$];
      lookup_result_type awaited[$];
      int                faults  = 0;
      int                reports = 0;

      function void await_result(status_type st, logic [KEY_W-1:0] k,
                                 logic [LOC_W-1:0] l, logic lst);
         lookup_result_type r;
         r.status = st;
         r.key    = k;
         r.loc    = l;
         r.last   = lst;
         awaited.push_back(r);
      endfunction

      function void note_request(mode_type m, logic [KEY_W-1:0] k, logic [LOC_W-1:0] l);
         int pos;
         bit hit;
         pos = 0;
         // find the first entry that is not below the key
         while (pos < sorted_keys.size() && sorted_keys[pos] < k)
            pos++;
         hit = (pos < sorted_keys.size()) && (sorted_keys[pos] == k);
         case (m)
            MODE_INSERT: begin
               // a duplicate wins over full: a present key is reported as such
               if (hit)
                  await_result(STAT_DUPLICATE, '0, '0, 1'b1);
               else if (sorted_keys.size() >= TABLE_DEPTH)
                  await_result(STAT_FULL, '0, '0, 1'b1);
               else begin
                  sorted_keys.insert(pos, k);
                  sorted_locs.insert(pos, l);
                  await_result(STAT_INSERTED, '0, '0, 1'b1);
               end
            end
            MODE_FIND: begin
               if (hit)
                  await_result(STAT_FOUND, '0, sorted_locs[pos], 1'b1);
               else
                  await_result(STAT_NOT_FOUND, '0, '0, 1'b1);
            end
            MODE_CLEAR: begin
               sorted_keys.delete();
               sorted_locs.delete();
               await_result(STAT_EMPTY, '0, '0, 1'b1);
            end
            default: begin
               if (sorted_keys.size() == 0)
                  await_result(STAT_EMPTY, '0, '0, 1'b1);
               else
                  foreach (sorted_keys[i])
                     await_result(STAT_LISTED, sorted_keys[i], sorted_locs[i],
                                  i == sorted_keys.size() - 1);
            end
         endcase
      endfunction

      function void mismatch(string field, logic [63:0] want_v, logic [63:0] got_v);
         faults++;
         if (reports < REPORT_CAP) begin
            reports++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want_v, got_v);
         end
      endfunction

      function void check_response(logic [STATUS_W-1:0] st, logic [KEY_W-1:0] k,
                                   logic [LOC_W-1:0] l, logic lst);
         lookup_result_type want;
         if (awaited.size() == 0) begin
            faults++;
            if (reports < REPORT_CAP) begin
               reports++;
               $display("%0t: response with none expected: status %h key %h loc %h last %b",
                        $time, st, k, l, lst);
            end
            return;
         end
         want = awaited.pop_front();
         if (st !== want.status)
            mismatch("status", want.status, st);
         if (k !== want.key)
            mismatch("key_out", want.key, k);
         if (l !== want.loc)
            mismatch("location_out", want.loc, l);
         if (lst !== want.last)
            mismatch("last", want.last, lst);
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [MODE_W-1:0]     req_tuser  = MODE_INSERT;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  rsp_tlast;

   table_tracker ledger      = new;
   bit           calm        = 1'b0;  // no gaps and no new stalls while set
   int           sent        = 0;
   int           fills       = 0;
   int           stall_left  = 0;
   int           idle_cycles = 0;

   always #5 clock = ~clock;

   sorted_symbol_table uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Mostly short gaps, now and then a long one.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75)
         return $urandom_range(1, 3);
      if (r < 95)
         return $urandom_range(4, 8);
      return $urandom_range(10, 40);
   endfunction

   // Pack a name the way the block expects: first character in the top byte.
   function automatic logic [KEY_W-1:0] symbol(string s);
      logic [KEY_W-1:0] k;
      logic [7:0]       c;
      k = '0;
      for (int i = 0; i < KEY_CHARS; i++) begin
         c = (i < s.len()) ? 8'(s[i]) : 8'h00;
         k = {k[KEY_W-9:0], c};
      end
      return k;
   endfunction

   // A plausible label: a letter, then letters and digits, zero padded.
   function automatic logic [KEY_W-1:0] rand_symbol();
      logic [KEY_W-1:0] k;
      logic [7:0]       c;
      int               len;
      k   = '0;
      len = $urandom_range(1, KEY_CHARS);
      for (int i = 0; i < KEY_CHARS; i++) begin
         if (i >= len)
            c = 8'h00;
         else if (i == 0 || $urandom_range(0, 3) != 0)
            c = 8'h41 + 8'($urandom_range(0, 25));
         else
            c = 8'h30 + 8'($urandom_range(0, 9));
         k = {k[KEY_W-9:0], c};
      end
      return k;
   endfunction

   function automatic logic [KEY_W-1:0] raw_key();
      logic [63:0] raw;
      raw = {$urandom(), $urandom()};
      return raw[KEY_W-1:0];
   endfunction

   function automatic logic [LOC_W-1:0] rand_loc();
      return LOC_W'($urandom());
   endfunction

   // Bias towards keys already held so that finds hit and inserts collide;
   // add neighbours of held keys to probe the ordering edges.
   function automatic logic [KEY_W-1:0] rand_key();
      logic [KEY_W-1:0] pick;
      int               r;
      int               held;
      r    = $urandom_range(0, 99);
      held = ledger.sorted_keys.size();
      if (held == 0 || r < 35)
         return (r < 90) ? rand_symbol() : raw_key();
      pick = ledger.sorted_keys[$urandom_range(0, held - 1)];
      if (r < 70)
         return pick;
      if (r < 88)
         return raw_key();
      if (r < 95)
         return $urandom_range(0, 1) ? pick + 1'b1 : pick - 1'b1;
      return $urandom_range(0, 1) ? '0 : '1;
   endfunction

   // Present one request, hold it until accepted, then note it in the ledger.
   task automatic send_request(mode_type m, logic [KEY_W-1:0] k, logic [LOC_W-1:0] l);
      int gap;
      gap = (calm || $urandom_range(0, 1) == 0) ? 0 : gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= m;
      req_tdata  <= {l, k};
      do @(posedge clock); while (!req_tready);
      ledger.note_request(m, k, l);
      sent++;
   endtask

   task automatic mixed_burst(int len);
      int r;
      repeat (len) begin
         r = $urandom_range(0, 99);
         if (r < 50)
            send_request(MODE_INSERT, rand_key(), rand_loc());
         else if (r < 85)
            send_request(MODE_FIND, rand_key(), rand_loc());
         else if (r < 96)
            send_request(MODE_LIST, rand_key(), rand_loc());
         else
            send_request(MODE_CLEAR, rand_key(), rand_loc());
      end
   endtask

   // Empty the table, fill it to the brim, then push at the full table.
   task automatic fill_table();
      int held;
      fills++;
      send_request(MODE_CLEAR, raw_key(), rand_loc());
      while (ledger.sorted_keys.size() < TABLE_DEPTH) begin
         if ($urandom_range(0, 7) == 0)
            send_request(MODE_FIND, rand_key(), rand_loc());
         else
            send_request(MODE_INSERT, ($urandom_range(0, 3) == 0) ? raw_key() : rand_symbol(),
                         rand_loc());
      end
      held = ledger.sorted_keys.size();
      // a new key is refused; a held key still reads as a duplicate
      send_request(MODE_INSERT, raw_key(), rand_loc());
      send_request(MODE_INSERT, ledger.sorted_keys[$urandom_range(0, held - 1)], rand_loc());
      send_request(MODE_FIND, ledger.sorted_keys[held - 1], rand_loc());
      send_request(MODE_LIST, raw_key(), rand_loc());
      mixed_burst($urandom_range(3, 8));
   endtask

   // Response side: check every accepted response, stall at random, watch for a hang.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         ledger.check_response(rsp_tuser, rsp_tdata[KEY_W-1:0], rsp_tdata[KEY_W +: LOC_W],
                               rsp_tlast);
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= gap_len() - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int r;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table behaviour, key and location extremes, ordering of a
      // prefix against a longer name, duplicate, hit and miss next to held keys.
      send_request(MODE_LIST, '0, '0);
      send_request(MODE_FIND, '0, '1);
      send_request(MODE_CLEAR, '1, '1);
      send_request(MODE_INSERT, '0, 16'hFFFF);
      send_request(MODE_INSERT, '1, 16'h0000);
      send_request(MODE_INSERT, symbol("MAIN"), 16'h1000);
      send_request(MODE_INSERT, symbol("A"), 16'hA5A5);
      send_request(MODE_INSERT, symbol("AB"), 16'h5A5A);
      send_request(MODE_INSERT, symbol("MAIN"), 16'h2222);
      send_request(MODE_FIND, symbol("MAIN"), '0);
      send_request(MODE_FIND, '1, '0);
      send_request(MODE_FIND, '0, '0);
      send_request(MODE_FIND, symbol("MAIM"), '0);
      send_request(MODE_FIND, {{(KEY_W-1){1'b1}}, 1'b0}, '0);
      send_request(MODE_LIST, '0, '0);
      send_request(MODE_CLEAR, '0, '0);
      send_request(MODE_FIND, symbol("MAIN"), '0);
      send_request(MODE_LIST, '0, '0);
      send_request(MODE_INSERT, {(KEY_W/2){2'b01}}, 16'hAAAA);
      send_request(MODE_INSERT, {(KEY_W/2){2'b10}}, 16'h5555);
      send_request(MODE_LIST, '1, '1);
      send_request(MODE_CLEAR, '0, '0);

      // Random: one full-table pass first, then bursts of mixed traffic with
      // the odd bout of pure noise and a clear-and-rebuild.
      fill_table();
      while (sent < REQUEST_TARGET) begin
         calm = ($urandom_range(0, 3) == 0);
         r    = $urandom_range(0, 9);
         if (r < 6)
            mixed_burst($urandom_range(8, 30));
         else if (r < 8)
            repeat ($urandom_range(4, 12))
               send_request(mode_type'($urandom_range(0, 3)), raw_key(), rand_loc());
         else if (r == 8 && fills < 2 && sent < REQUEST_TARGET / 2)
            fill_table();
         else begin
            send_request(MODE_CLEAR, rand_key(), rand_loc());
            mixed_burst($urandom_range(5, 12));
            send_request(MODE_LIST, rand_key(), rand_loc());
         end
      end

      // Drain: drop valid, wait for every response, then watch for strays.
      calm = 1'b0;
      req_tvalid <= 1'b0;
      while (ledger.awaited.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (ledger.faults == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
